// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the Bernstein basis RTL (used by abb_seq).
// Checks compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ABB_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ABB_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ABB_ASSERT(label, clk, rstn, prop)
`define ABB_NEVER(label, clk, rstn, cond)
`endif
`endif

// ----- hw/rtl/abb_pkg.sv -----
`timescale 1ns / 1ps
// Types and constants for the Bernstein basis generator.
// No dependencies; used by abb_cell, abb_seq and all_bernstein_basis.
package abb_pkg;

    localparam int VAL_W     = 16;
    localparam int FRAC_BITS = 15;
    localparam int IDX_W     = 4;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [VAL_W-1:0]  ONE_FX  = VAL_W'(1 << FRAC_BITS);
    localparam logic [PROD_W-1:0] HALF_FX = PROD_W'(1 << (FRAC_BITS - 1));

    // register word select: paddr[ADDR_W-1:2]
    localparam logic [ADDR_W-3:0] REG_DEGREE = '0;
    localparam logic [IDX_W-1:0]  DEGREE_RESET = IDX_W'(3);

    typedef struct packed {
        logic load;   // seed the row with 1.0, 0, 0, ...
        logic step;   // one round of the recurrence
        logic shift;  // move the row one cell toward cell 0
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } state_t;

endpackage

// ----- hw/rtl/abb_cell.sv -----
`timescale 1ns / 1ps
// One cell of the basis row: holds one entry and updates it each round.
// Depends on abb_pkg.
module abb_cell (
    input  logic                        clk,
    input  abb_pkg::cell_ctl_t          ctl,
    input  logic [abb_pkg::VAL_W-1:0]   seed,
    input  logic [abb_pkg::VAL_W-1:0]   u_val,
    input  logic [abb_pkg::VAL_W-1:0]   u1_val,
    input  logic [abb_pkg::VAL_W-1:0]   left_val,
    input  logic [abb_pkg::VAL_W-1:0]   right_val,
    output logic [abb_pkg::VAL_W-1:0]   val
);

    logic [abb_pkg::VAL_W-1:0]  val_reg;
    logic [abb_pkg::VAL_W-1:0]  val_next;
    logic [abb_pkg::PROD_W-1:0] keep_prod;
    logic [abb_pkg::PROD_W-1:0] take_prod;
    logic [abb_pkg::PROD_W-1:0] keep_rnd;
    logic [abb_pkg::PROD_W-1:0] take_rnd;
    logic [abb_pkg::VAL_W:0]    sum;
    logic [abb_pkg::VAL_W-1:0]  sat;

    assign keep_prod = abb_pkg::PROD_W'(u1_val) * abb_pkg::PROD_W'(val_reg);
    assign take_prod = abb_pkg::PROD_W'(u_val) * abb_pkg::PROD_W'(left_val);
    assign keep_rnd  = keep_prod + abb_pkg::HALF_FX;
    assign take_rnd  = take_prod + abb_pkg::HALF_FX;

    assign sum = {1'b0, keep_rnd[abb_pkg::FRAC_BITS +: abb_pkg::VAL_W]}
               + {1'b0, take_rnd[abb_pkg::FRAC_BITS +: abb_pkg::VAL_W]};

    // clip rounding overshoot at 1.0
    assign sat = (sum > {1'b0, abb_pkg::ONE_FX}) ? abb_pkg::ONE_FX
                                                 : sum[abb_pkg::VAL_W-1:0];

    always_comb
    begin
        priority if (ctl.load)
        begin
            val_next = seed;
        end
        else if (ctl.step)
        begin
            val_next = sat;
        end
        else if (ctl.shift)
        begin
            val_next = right_val;
        end
        else
        begin
            val_next = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ----- hw/rtl/abb_seq.sv -----
`timescale 1ns / 1ps
// Sequencer: accepts requests, runs the rounds over the cell row and
// drains the row into the output register. Depends on abb_pkg.
`include "assert_macros.svh"
module abb_seq #(
    parameter int MAX_DEGREE = 15
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [abb_pkg::IDX_W-1:0]   degree,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [abb_pkg::VAL_W-1:0]   u,
    output abb_pkg::cell_ctl_t          ctl,
    output logic [abb_pkg::VAL_W-1:0]   u_val,
    output logic [abb_pkg::VAL_W-1:0]   u1_val,
    input  logic [abb_pkg::VAL_W-1:0]   head_val,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [abb_pkg::IDX_W-1:0]   index,
    output logic [abb_pkg::VAL_W-1:0]   value,
    output logic                        last
);

    abb_pkg::state_t state_reg, state_next;

    logic [abb_pkg::IDX_W-1:0] n_reg;
    logic [abb_pkg::IDX_W-1:0] cnt_reg;
    logic [abb_pkg::IDX_W-1:0] n_calc;
    logic [abb_pkg::VAL_W-1:0] u_reg;
    logic [abb_pkg::VAL_W-1:0] u1_reg;
    logic [abb_pkg::VAL_W-1:0] u_clip;
    logic                      out_valid_reg;
    logic [abb_pkg::IDX_W-1:0] out_index_reg;
    logic [abb_pkg::VAL_W-1:0] out_value_reg;
    logic                      out_last_reg;
    logic                      accept;
    logic                      emit_fire;

    assign u_clip = (u > abb_pkg::ONE_FX) ? abb_pkg::ONE_FX : u;
    assign n_calc = (32'(degree) > MAX_DEGREE) ? abb_pkg::IDX_W'(MAX_DEGREE) : degree;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            abb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (n_calc == '0) ? abb_pkg::ST_EMIT : abb_pkg::ST_CALC;
                end
            end
            abb_pkg::ST_CALC:
            begin
                if (cnt_reg == n_reg)
                begin
                    state_next = abb_pkg::ST_EMIT;
                end
            end
            abb_pkg::ST_EMIT:
            begin
                if (emit_fire && (cnt_reg == n_reg))
                begin
                    state_next = abb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = abb_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        in_stall  = (state_reg != abb_pkg::ST_IDLE);
        accept    = (state_reg == abb_pkg::ST_IDLE) && in_valid;
        emit_fire = (state_reg == abb_pkg::ST_EMIT) && (!out_valid_reg || !out_stall);
        ctl.load  = accept;
        ctl.step  = (state_reg == abb_pkg::ST_CALC);
        ctl.shift = emit_fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= abb_pkg::ST_IDLE;
            cnt_reg       <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                n_reg   <= n_calc;
                cnt_reg <= (n_calc == '0) ? '0 : abb_pkg::IDX_W'(1);
            end
            else if (ctl.step)
            begin
                cnt_reg <= (cnt_reg == n_reg) ? '0 : cnt_reg + 1'b1;
            end
            else if (emit_fire)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            u_reg  <= u_clip;
            u1_reg <= abb_pkg::ONE_FX - u_clip;
        end
        // take the head of the row while the rest shifts down
        if (emit_fire)
        begin
            out_index_reg <= cnt_reg;
            out_value_reg <= head_val;
            out_last_reg  <= (cnt_reg == n_reg);
        end
    end

    assign u_val     = u_reg;
    assign u1_val    = u1_reg;
    assign out_valid = out_valid_reg;
    assign index     = out_index_reg;
    assign value     = out_value_reg;
    assign last      = out_last_reg;

    `ABB_ASSERT(a_ctl_exclusive, clk, rst_n, $onehot0({ctl.load, ctl.step, ctl.shift}))
    `ABB_ASSERT(a_calc_count, clk, rst_n, (state_reg == abb_pkg::ST_CALC) |-> ((cnt_reg != '0) && (cnt_reg <= n_reg)))
    `ABB_ASSERT(a_last_to_idle, clk, rst_n, (emit_fire && (cnt_reg == n_reg)) |=> (state_reg == abb_pkg::ST_IDLE) && out_last_reg)
    `ABB_NEVER(a_emit_past_end, clk, rst_n, (state_reg == abb_pkg::ST_EMIT) && (cnt_reg > n_reg))

endmodule

// ----- hw/rtl/all_bernstein_basis.sv -----
`timescale 1ns / 1ps
// Bernstein basis generator, top level: register port, sequencer and cell row.
// Depends on abb_pkg, abb_cell and abb_seq.
//
// Usage: write the degree n (0..15, saturated to MAX_DEGREE) at byte address 0
// over the APB port while the block is idle; it resets to 3. Send a request on
// the input channel (in_valid/in_stall) carrying u in Q1.15; u above 1.0 is
// clipped to 1.0. The block answers with n+1 results on the output channel
// (out_valid/out_stall), index 0 first, last set on index n.
// A request is accepted, then n rounds run in which every cell of the row
// updates at once (two 16x16 multiplies per cell), then the row shifts toward
// cell 0 and drains one result per cycle while the output is not stalled.
// in_stall stays high from accept until the last result has been loaded into
// the output register. A stalled output holds its result and freezes the
// drain. Reset clears the control state and empties the output.
module all_bernstein_basis #(
    parameter int MAX_DEGREE = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [abb_pkg::ADDR_W-1:0]    paddr,
    input  logic [abb_pkg::DATA_W-1:0]    pwdata,
    output logic [abb_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [abb_pkg::VAL_W-1:0]     u,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [abb_pkg::IDX_W-1:0]     index,
    output logic [abb_pkg::VAL_W-1:0]     value,
    output logic                          last
);

    localparam int NCELL = MAX_DEGREE + 1;

    logic [abb_pkg::IDX_W-1:0] degree_reg;
    logic                      reg_hit;
    abb_pkg::cell_ctl_t        ctl;
    logic [abb_pkg::VAL_W-1:0] u_val;
    logic [abb_pkg::VAL_W-1:0] u1_val;
    logic [abb_pkg::VAL_W-1:0] cell_val [NCELL];

    assign pready  = 1'b1;
    assign reg_hit = (paddr[abb_pkg::ADDR_W-1:2] == abb_pkg::REG_DEGREE);
    assign prdata  = reg_hit ? abb_pkg::DATA_W'(degree_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= abb_pkg::DEGREE_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            degree_reg <= pwdata[abb_pkg::IDX_W-1:0];
        end
    end

    abb_seq #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .degree    (degree_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .u         (u),
        .ctl       (ctl),
        .u_val     (u_val),
        .u1_val    (u1_val),
        .head_val  (cell_val[0]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .index     (index),
        .value     (value),
        .last      (last)
    );

    // the row: cell k holds entry k; left neighbor feeds the u term,
    // right neighbor feeds the drain
    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        logic [abb_pkg::VAL_W-1:0] left_val;
        logic [abb_pkg::VAL_W-1:0] right_val;
        logic [abb_pkg::VAL_W-1:0] seed;

        if (k == 0)
        begin : g_head
            assign left_val = '0;
            assign seed     = abb_pkg::ONE_FX;
        end
        else
        begin : g_body
            assign left_val = cell_val[k-1];
            assign seed     = '0;
        end

        if (k == NCELL - 1)
        begin : g_tail
            assign right_val = '0;
        end
        else
        begin : g_inner
            assign right_val = cell_val[k+1];
        end

        abb_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .seed      (seed),
            .u_val     (u_val),
            .u1_val    (u1_val),
            .left_val  (left_val),
            .right_val (right_val),
            .val       (cell_val[k])
        );
    end

endmodule
